>>> rtl/pktb_pkg.sv
// Package for the per-key token bucket limiter: sizes, field widths, shared types.
// No dependencies.
`timescale 1ns / 1ps
package pktb_pkg;
  localparam int unsigned Slots     = 1024;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned CntW      = SlotW + 1;
  localparam int unsigned KeyW      = 32;
  localparam int unsigned TokW      = 16;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned PerW      = 20;
  localparam int unsigned SpanW     = PerW + TokW;
  localparam int unsigned QuoW      = TimeW;

  localparam logic [0:0] CfgPeriod = 1'b0;
  localparam logic [0:0] CfgCap    = 1'b1;

  // one bucket entry as stored in the slot memory
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [TokW-1:0]  tokens;
    logic [TimeW-1:0] stamp;
  } slot_t;

  // control from the sequencer to the refill divider
  typedef struct packed {
    logic              go;
    logic [SpanW-1:0]  dividend;
  } div_req_t;
endpackage

>>> rtl/pktb_slot_ram.sv
// Slot memory of the limiter: one write port, one read port, registered read.
// Depends on pktb_pkg.
`timescale 1ns / 1ps
module pktb_slot_ram (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [pktb_pkg::SlotW-1:0] waddr_i,
  input  pktb_pkg::slot_t       wdata_i,
  input  logic [pktb_pkg::SlotW-1:0] raddr_i,
  output pktb_pkg::slot_t       rdata_o
);
  import pktb_pkg::*;
  slot_t mem_q [Slots];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/pktb_div.sv
// Restoring divider, one quotient bit per cycle: elapsed span / period.
// Depends on pktb_pkg.
`timescale 1ns / 1ps
module pktb_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pktb_pkg::div_req_t          req_i,
  input  logic [pktb_pkg::PerW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [pktb_pkg::SpanW-1:0]  quo_o
);
  import pktb_pkg::*;
  localparam int unsigned StepW = $clog2(SpanW + 1);
  logic [SpanW-1:0] quo_q, quo_d;
  logic [PerW:0]    rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [PerW:0]    trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[PerW-1:0], quo_q[SpanW-1]};
    if (req_i.go) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      step_d = StepW'(SpanW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial - {1'b0, divisor_i};
        quo_d = {quo_q[SpanW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SpanW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

>>> rtl/per_key_token_bucket_limiter.sv
// Top level of the per-key token bucket limiter: sequencer, counters, clearing pass.
// Depends on pktb_pkg, pktb_slot_ram, pktb_div.
`timescale 1ns / 1ps
// Per-key token bucket limiter. Each transaction (start while not busy) is a
// client request or a sweep and yields exactly one result, shown for one cycle
// with done_o; the receiver cannot stall it. Buckets, valid bits included, live
// in a 1024-entry slot memory with a registered read. After reset a clearing
// pass writes every slot invalid; busy_o stays high throughout the pass. The
// slot walk reads each slot and then compares its data, and every valid bucket
// that is matched or swept gets a refill divide. A request whose key sits in a
// slot stops the walk there; a request for a new key walks all slots, as does
// a sweep. A request for a new key while the table is full runs a sweep first.
// Configuration writes are taken at any time via cfg_valid_i/cfg_ready_o and
// must only be issued while the block is idle.
module per_key_token_bucket_limiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         func_i,
  input  logic [pktb_pkg::KeyW-1:0]    client_addr_i,
  input  logic [pktb_pkg::TimeW-1:0]   now_us_i,
  output logic                         done_o,
  output logic                         limited_o,
  output logic [pktb_pkg::CntW-1:0]    entries_used_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [0:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import pktb_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLook  = 4'd1; // walk slots for key match
  localparam logic [3:0] StLookW = 4'd2; // compare read data
  localparam logic [3:0] StDiv   = 4'd3; // refill divide running
  localparam logic [3:0] StUpd   = 4'd4; // apply refill
  localparam logic [3:0] StSwRd  = 4'd5; // sweep: issue read
  localparam logic [3:0] StSwCmp = 4'd6; // sweep: data back
  localparam logic [3:0] StIns   = 4'd7; // insert at lowest free slot
  localparam logic [3:0] StDone  = 4'd8;
  localparam logic [3:0] StClr   = 4'd9;  // clearing pass after reset
  localparam logic [3:0] StSwDiv = 4'd10; // sweep: refill divide, then evict test

  logic [3:0]        state_q, state_d;
  logic [PerW-1:0]   period_q;
  logic [TokW-1:0]   cap_q;
  logic [CntW-1:0]   used_q, used_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]  free_q, free_d;
  logic              free_ok_q, free_ok_d;
  logic              func_q, sweep_pre_q, sweep_pre_d;
  logic [KeyW-1:0]   key_q;
  logic [TimeW-1:0]  now_q;
  logic              lim_q, lim_d, done_q, done_d;
  slot_t             rd, wdata;
  logic              we;
  logic [SlotW-1:0]  waddr;
  logic [SlotW-1:0]  raddr;
  div_req_t          dreq;
  logic              ddone;
  logic [SpanW-1:0]  quo;
  logic [PerW-1:0]   per_eff;
  logic [SpanW-1:0]  span;
  logic [TimeW-1:0]  elapsed;
  logic [SpanW:0]    level_raw;
  logic [TokW-1:0]   level;
  logic [SpanW-1:0]  span_q;

  assign cfg_ready_o = 1'b1;
  assign per_eff = (period_q == '0) ? PerW'(1) : period_q;
  // one 20x16 multiply, registered
  always_ff @(posedge clk_i) begin
    span_q <= SpanW'(per_eff) * SpanW'(cap_q);
  end
  assign span = span_q;

  pktb_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  pktb_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dreq),
    .divisor_i (per_eff),
    .done_o    (ddone),
    .quo_o     (quo)
  );

  assign elapsed   = now_q - rd.stamp;
  assign level_raw = (SpanW+1)'(rd.tokens) + (SpanW+1)'(quo);
  assign level     = (level_raw > (SpanW+1)'(cap_q)) ? cap_q : level_raw[TokW-1:0];
  assign raddr     = idx_q[SlotW-1:0];

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    free_d      = free_q;
    free_ok_d   = free_ok_q;
    sweep_pre_d = sweep_pre_q;
    lim_d       = lim_q;
    done_d      = 1'b0;
    we          = 1'b0;
    waddr       = idx_q[SlotW-1:0];
    wdata       = rd;
    dreq.go       = 1'b0;
    dreq.dividend = (elapsed > TimeW'(span)) ? span : elapsed[SpanW-1:0];
    case (state_q)
      StClr: begin
        we    = 1'b1;
        wdata = '0;
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(Slots - 1)) begin
          idx_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          idx_d       = '0;
          lim_d       = 1'b0;
          sweep_pre_d = 1'b0;
          free_ok_d   = 1'b0;
          state_d     = func_i ? StSwRd : StLook;
        end
      end
      StLook: begin
        if (idx_q == CntW'(Slots)) begin
          if (used_q >= CntW'(Slots)) begin
            sweep_pre_d = 1'b1;
            free_ok_d   = 1'b0;
            idx_d       = '0;
            state_d     = StSwRd;
          end else begin
            state_d = StIns;
          end
        end else begin
          state_d = StLookW;
        end
      end
      StLookW: begin
        if (rd.valid && rd.key == key_q) begin
          dreq.go = 1'b1;
          state_d = StDiv;
        end else begin
          // remember the lowest free slot for a later insert
          if (!rd.valid && !free_ok_q) begin
            free_d    = idx_q[SlotW-1:0];
            free_ok_d = 1'b1;
          end
          idx_d   = idx_q + CntW'(1);
          state_d = StLook;
        end
      end
      StDiv: begin
        if (ddone) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        we = 1'b1;
        if (level == '0) begin
          wdata.tokens = '0;
          lim_d        = 1'b1;
        end else begin
          wdata.tokens = level - TokW'(1);
          wdata.stamp  = now_q;
        end
        state_d = StDone;
      end
      StSwRd: begin
        if (idx_q == CntW'(Slots)) begin
          if (sweep_pre_q) begin
            if (used_q >= CntW'(Slots)) begin
              lim_d   = 1'b1;
              state_d = StDone;
            end else begin
              state_d = StIns;
            end
          end else begin
            state_d = StDone;
          end
        end else begin
          state_d = StSwCmp;
        end
      end
      StSwCmp: begin
        if (rd.valid) begin
          dreq.go = 1'b1;
          state_d = StSwDiv;
        end else begin
          if (!free_ok_q) begin
            free_d    = idx_q[SlotW-1:0];
            free_ok_d = 1'b1;
          end
          idx_d   = idx_q + CntW'(1);
          state_d = StSwRd;
        end
      end
      StSwDiv: begin
        // rd still holds slot idx: the read address has not moved
        if (ddone) begin
          if (level >= cap_q) begin
            we          = 1'b1;
            wdata.valid = 1'b0;
            used_d      = used_q - CntW'(1);
            if (!free_ok_q) begin
              free_d    = idx_q[SlotW-1:0];
              free_ok_d = 1'b1;
            end
          end
          idx_d   = idx_q + CntW'(1);
          state_d = StSwRd;
        end
      end
      StIns: begin
        if (free_ok_q) begin
          we           = 1'b1;
          waddr        = free_q;
          wdata.valid  = 1'b1;
          wdata.key    = key_q;
          wdata.tokens = (cap_q == '0) ? '0 : cap_q - TokW'(1);
          wdata.stamp  = now_q;
          used_d       = used_q + CntW'(1);
        end else begin
          lim_d = 1'b1;
        end
        state_d = StDone;
      end
      StDone: begin
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      used_q      <= '0;
      idx_q       <= '0;
      free_q      <= '0;
      free_ok_q   <= 1'b0;
      func_q      <= 1'b0;
      sweep_pre_q <= 1'b0;
      lim_q       <= 1'b0;
      done_q      <= 1'b0;
      period_q    <= PerW'(20000);
      cap_q       <= TokW'(600);
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      free_q      <= free_d;
      free_ok_q   <= free_ok_d;
      sweep_pre_q <= sweep_pre_d;
      lim_q       <= lim_d;
      done_q      <= done_d;
      if (state_q == StIdle && start_i) begin
        func_q <= func_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgPeriod: period_q <= cfg_data_i[PerW-1:0];
          CfgCap:    cap_q    <= cfg_data_i[TokW-1:0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      key_q  <= client_addr_i;
      now_q  <= now_us_i;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign done_o         = done_q;
  assign limited_o      = lim_q & ~func_q;
  assign entries_used_o = used_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == StIdle) else $error("result while not idle");
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(Slots)) else $error("bucket count overflow");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item did not raise busy");
endmodule

>>> sim/pktb_checker.sv
// Checker for the per-key token bucket limiter: tracks transactions and config writes,
// predicts each result from its own bucket table and compares. Depends on pktb_pkg.
`timescale 1ns / 1ps
module pktb_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       func_i,
  input  logic [pktb_pkg::KeyW-1:0]  client_addr_i,
  input  logic [pktb_pkg::TimeW-1:0] now_us_i,
  input  logic                       done_i,
  input  logic                       limited_i,
  input  logic [pktb_pkg::CntW-1:0]  entries_used_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o,
  output int unsigned                results_o,
  output int unsigned                limited_count_o
);
  import pktb_pkg::*;

  typedef struct packed {
    logic            limited;
    logic [CntW-1:0] used;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [PerW-1:0]  period;
  logic [TokW-1:0]  capacity;
  logic             live [Slots];
  logic [KeyW-1:0]  key_tab [Slots];
  logic [TokW-1:0]  tok_tab [Slots];
  logic [TimeW-1:0] stamp_tab [Slots];
  int unsigned      occupancy;

  assign pending_o = verdict_q.size();

  // tokens a bucket would hold after a refill to now
  function automatic longint unsigned refilled(int s, logic [TimeW-1:0] now);
    longint unsigned per, span, el, lv;
    logic [TimeW-1:0] diff;
    per  = (period == 0) ? 64'd1 : 64'(period);
    span = per * 64'(capacity);
    diff = now - stamp_tab[s];
    el   = 64'(diff);
    if (el > span) el = span;
    lv = 64'(tok_tab[s]) + el / per;
    if (lv > 64'(capacity)) lv = 64'(capacity);
    return lv;
  endfunction

  function automatic void evict_full(logic [TimeW-1:0] now);
    for (int s = 0; s < Slots; s++) begin
      if (live[s] && refilled(s, now) >= 64'(capacity)) begin
        live[s] = 1'b0;
        occupancy--;
      end
    end
  endfunction

  function automatic logic admit(logic [KeyW-1:0] addr, logic [TimeW-1:0] now);
    longint unsigned lv;
    for (int s = 0; s < Slots; s++) begin
      if (live[s] && key_tab[s] == addr) begin
        lv = refilled(s, now);
        if (lv == 0) begin
          tok_tab[s] = '0;
          return 1'b1;
        end
        tok_tab[s]   = TokW'(lv - 1);
        stamp_tab[s] = now;
        return 1'b0;
      end
    end
    if (occupancy >= Slots) begin
      evict_full(now);
      if (occupancy >= Slots) return 1'b1;
    end
    for (int s = 0; s < Slots; s++) begin
      if (!live[s]) begin
        live[s]      = 1'b1;
        key_tab[s]   = addr;
        tok_tab[s]   = (capacity == 0) ? '0 : capacity - TokW'(1);
        stamp_tab[s] = now;
        occupancy++;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      period          = PerW'(20000);
      capacity        = TokW'(600);
      occupancy       = 0;
      fail_count_o    = 0;
      results_o       = 0;
      limited_count_o = 0;
      for (int s = 0; s < Slots; s++) live[s] = 1'b0;
      verdict_q.delete();
    end else begin
      // compare first: a result may leave in the same cycle a new item enters
      if (done_i) begin
        results_o++;
        if (limited_i) limited_count_o++;
        if (verdict_q.size() == 0) begin
          $error("result with nothing expected: limited=%0b entries_used=%0d",
                 limited_i, entries_used_i);
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (limited_i !== want.limited) begin
            $error("limited: expected %0b, got %0b", want.limited, limited_i);
            fail_count_o++;
          end
          if (entries_used_i !== want.used) begin
            $error("entries_used: expected %0d, got %0d", want.used, entries_used_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgPeriod) period = cfg_data_i[PerW-1:0];
        else capacity = cfg_data_i[TokW-1:0];
      end
      if (start_i && !busy_i) begin
        want.limited = 1'b0;
        if (func_i) evict_full(now_us_i);
        else want.limited = admit(client_addr_i, now_us_i);
        want.used = CntW'(occupancy);
        verdict_q.push_back(want);
      end
    end
  end
endmodule

>>> sim/tb_per_key_token_bucket_limiter.sv
// Testbench top for the per-key token bucket limiter: clock, reset, stimulus, verdict.
// Depends on pktb_pkg, pktb_checker and the limiter RTL.
`timescale 1ns / 1ps
module tb_per_key_token_bucket_limiter;
  import pktb_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              func_i = 1'b0;
  logic [KeyW-1:0]   client_addr_i = '0;
  logic [TimeW-1:0]  now_us_i = '0;
  logic              done_o;
  logic              limited_o;
  logic [CntW-1:0]   entries_used_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index_i = CfgPeriod;
  logic [31:0]       cfg_data_i = '0;

  int unsigned fail_count, pending, results, limited_count;
  int unsigned sent_count = 0;
  int unsigned cfg_count  = 0;
  int unsigned idle_pct   = 0;

  // current period and time base, kept for shaping the stimulus
  int unsigned     cur_period = 20000;
  logic [TimeW-1:0] clock_us  = '0;
  logic [KeyW-1:0]  client_pool [16];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  per_key_token_bucket_limiter dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .client_addr_i, .now_us_i,
    .done_o, .limited_o, .entries_used_o, .cfg_valid_i,
    .cfg_ready_o(cfg_ready), .cfg_index_i, .cfg_data_i
  );

  pktb_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .client_addr_i, .now_us_i,
    .done_i(done_o), .limited_i(limited_o), .entries_used_i(entries_used_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .limited_count_o(limited_count)
  );

  // One transaction. Inputs move on the falling edge; busy is stable there, so
  // start seen with busy low means the next rising edge takes it.
  task automatic issue(logic fn, logic [KeyW-1:0] addr, logic [TimeW-1:0] now);
    func_i        = fn;
    client_addr_i = addr;
    now_us_i      = now;
    start_i       = 1'b1;
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
    sent_count++;
    if ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      func_i        = 1'($urandom_range(1));
      client_addr_i = $urandom;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  // wait for the block to drain before touching a register
  task automatic settle();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // upper data bits are don't-care for the narrow registers; toggle them anyway
  task automatic write_reg(logic [0:0] idx, int unsigned val);
    cfg_index_i = idx;
    cfg_data_i  = (idx == CfgPeriod) ? {12'($urandom_range(4095)), val[PerW-1:0]}
                                     : {16'($urandom), val[TokW-1:0]};
    cfg_valid_i = 1'b1;
    while (!cfg_ready) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_count++;
    if (idx == CfgPeriod) cur_period = val;
  endtask

  task automatic set_rates(int unsigned per, int unsigned cap);
    settle();
    write_reg(CfgPeriod, per);
    write_reg(CfgCap, cap);
  endtask

  // Random traffic: mostly repeat clients with time creeping forward on the
  // scale of the token period, a few new clients, sweeps and time jumps.
  task automatic random_burst(int unsigned n);
    int unsigned pick, per;
    logic [KeyW-1:0] addr;
    for (int i = 0; i < n; i++) begin
      per  = (cur_period == 0) ? 1 : cur_period;
      pick = $urandom_range(99);
      if (pick < 3) clock_us = TimeW'({$urandom, $urandom});
      else clock_us = clock_us + TimeW'($urandom_range(0, 3 * per));
      if ($urandom_range(99) < 8) begin
        issue(1'b1, $urandom, clock_us);
      end else begin
        addr = ($urandom_range(99) < 10) ? $urandom : client_pool[$urandom_range(15)];
        issue(1'b0, addr, clock_us);
      end
    end
  endtask

  initial begin
    client_pool[0] = '0;
    client_pool[1] = '1;
    for (int i = 2; i < 16; i++) client_pool[i] = $urandom;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset rates, empty sweep, extreme keys and times
    issue(1'b1, '0, '0);
    issue(1'b0, '0, '0);
    issue(1'b0, '1, 48'hFFFF_FFFF_FFFF);
    issue(1'b0, '0, 48'd1);
    issue(1'b0, '1, 48'd5);              // time wrapped past the stamp
    issue(1'b1, '0, 48'hFFFF_FFFF_FFFF);

    // one token per microsecond, single-token buckets: drain and refill
    set_rates(1, 1);
    issue(1'b0, 32'h0A00_0001, 48'd100);
    issue(1'b0, 32'h0A00_0001, 48'd100); // empty bucket is rejected
    issue(1'b0, 32'h0A00_0001, 48'd101);
    issue(1'b1, '0, 48'd200);            // bucket refilled, evicted

    // zero period acts as one; zero capacity makes every bucket full
    set_rates(0, 0);
    issue(1'b0, 32'hC0A8_0101, 48'd10);
    issue(1'b0, 32'hC0A8_0101, 48'd11);
    issue(1'b0, 32'hC0A8_0102, 48'd12);
    issue(1'b1, '0, 48'd12);

    // widest capacity with a large period, then capacity lowered beneath stored tokens
    set_rates(1000000, 65535);
    issue(1'b0, 32'h7F00_0001, 48'hFFFF_FFFF_0000);
    issue(1'b0, 32'h7F00_0001, 48'h0000_0001_0000);
    issue(1'b0, 32'h7F00_0002, 48'd0);
    set_rates(1000000, 3);
    issue(1'b0, 32'h7F00_0001, 48'h0000_0001_0001);
    issue(1'b0, 32'h7F00_0002, 48'd1);
    issue(1'b1, '0, 48'h8000_0000_0000);

    // random phases over several rate settings and idle mixes
    clock_us = '0;
    set_rates(3, 4);           idle_pct = 0;  random_burst(130);
    set_rates($urandom_range(1, 50), $urandom_range(1, 8));
                               idle_pct = 51; random_burst(130);
    set_rates(1000000, 65535); idle_pct = 12; random_burst(130);
    set_rates(1, 1);           idle_pct = 0;  random_burst(140);

    settle();
    repeat (2000) @(negedge clk_i);
    $display("%0d transactions (%0d limited) over %0d register writes, %0d results checked",
             sent_count, limited_count, cfg_count, results);
    if (fail_count == 0 && pending == 0) begin
      $display("per_key_token_bucket_limiter verification clean");
    end else begin
      $display("per_key_token_bucket_limiter verification failed");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("per_key_token_bucket_limiter verification failed");
    $finish;
  end
endmodule
